### rtl/fsd_pkg.sv
// Package: types and constants of the field separator detector.
package fsd_pkg;

    localparam int NSEP = 4;

    // Candidate separators by slot: comma, tab, space, semicolon.
    localparam logic [7:0] SEP_BYTES [NSEP] = '{8'h2C, 8'h09, 8'h20, 8'h3B};

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [15:0] MAX_LINE_RESET   = 16'hFFFF;
    localparam logic [3:0]  CHECK_ROWS_RESET = 4'd10;

    typedef enum logic [0:0] {
        REG_MAX_LINE_LENGTH = 1'b0,
        REG_CHECK_ROWS      = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_DATA   = 3'b010,
        PH_CHECK  = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_NO_LINE = 2'd1,
        ST_NO_SEP  = 2'd2,
        ST_AMBIG   = 2'd3
    } status_t;

endpackage

### rtl/field_separator_detector_top.sv
// Top level: field separator detector over a byte stream.
// Result path: an end-of-data beat goes through the input register, then the result register,
//   and its result shows on m_tvalid; data bytes give no result.
// Throughput: one beat per cycle; a result still waiting in the output register stalls
//   only an end-of-data beat behind it, and the stream behind that, until it is taken.
// Reset: rst_n clears all line state and loads max_line_length 65535, check_rows 10.
module field_separator_detector_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_data
    // Decision out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] header separator byte, [15:8] row separator byte
    output logic [1:0]  m_tuser    // [1:0] status
);
    import fsd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = {COUNT_WIDTH{1'b0}};

    // Configuration registers
    logic [15:0] max_len_reg;
    logic [3:0]  check_rows_reg;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Line and file state
    phase_t                 phase_reg, phase_next, phase_eff;
    logic                   acr_reg, acr_next;
    logic [15:0]            chunk_reg, chunk_next;
    logic [3:0]             rows_reg, rows_next, rows_eff;
    logic [COUNT_WIDTH-1:0] lc_reg   [NSEP];
    logic [COUNT_WIDTH-1:0] lc_next  [NSEP];
    logic [COUNT_WIDTH-1:0] lc_inc   [NSEP];
    logic [COUNT_WIDTH-1:0] el_cnt   [NSEP];
    logic [COUNT_WIDTH-1:0] hdr_reg  [NSEP];
    logic [COUNT_WIDTH-1:0] hdr_next [NSEP];
    logic [COUNT_WIDTH-1:0] hdr_eff  [NSEP];
    logic [COUNT_WIDTH-1:0] row_reg  [NSEP];
    logic [COUNT_WIDTH-1:0] row_next [NSEP];
    logic [COUNT_WIDTH-1:0] row_eff  [NSEP];
    logic [NSEP-1:0]        incon_reg, incon_next, incon_eff;

    // Output register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    status_t     m_status_reg;

    logic        proc;
    logic        el_do;
    logic        el_ne;
    logic [15:0] chunk_inc;
    status_t     dec_status;
    logic [7:0]  dec_hs;
    logic [7:0]  dec_ds;

    // Advance the held beat unless it is end of data and the result slot is still full.
    assign proc     = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    assign chunk_inc = chunk_reg + 16'd1;

    // Byte handling: line splitting, separator counting, end of line.
    always_comb
    begin
        acr_next   = acr_reg;
        chunk_next = chunk_reg;
        phase_eff  = phase_reg;
        rows_eff   = rows_reg;
        incon_eff  = incon_reg;
        el_do      = 1'b0;
        el_ne      = 1'b0;
        for (int i = 0; i < NSEP; i++)
        begin
            lc_inc[i]  = (in_byte_reg == SEP_BYTES[i] && lc_reg[i] != CNT_MAX)
                         ? lc_reg[i] + {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : lc_reg[i];
            lc_next[i] = lc_reg[i];
            el_cnt[i]  = lc_reg[i];
            hdr_eff[i] = hdr_reg[i];
            row_eff[i] = row_reg[i];
        end

        if (in_last_reg)
        begin
            // Finish a pending line before the decision.
            acr_next = 1'b0;
            el_do    = 1'b1;
            el_ne    = (chunk_reg != 16'd0);
        end
        else if (acr_reg && in_byte_reg == CHAR_LF)
        begin
            // Swallow the LF of a CR LF pair.
            acr_next = 1'b0;
        end
        else if (in_byte_reg == CHAR_LF || in_byte_reg == CHAR_CR)
        begin
            el_do    = 1'b1;
            el_ne    = (chunk_reg != 16'd0);
            acr_next = (in_byte_reg == CHAR_CR);
        end
        else
        begin
            acr_next   = 1'b0;
            chunk_next = chunk_inc;
            for (int i = 0; i < NSEP; i++)
            begin
                lc_next[i] = lc_inc[i];
                el_cnt[i]  = lc_inc[i];
            end
            // Cut an overlong line into a new chunk.
            if (chunk_inc == max_len_reg)
            begin
                el_do = 1'b1;
                el_ne = 1'b1;
            end
        end

        if (el_do)
        begin
            chunk_next = 16'd0;
            for (int i = 0; i < NSEP; i++)
            begin
                lc_next[i] = CNT_ZERO;
            end
            if (el_ne)
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        for (int i = 0; i < NSEP; i++)
                        begin
                            hdr_eff[i] = el_cnt[i];
                        end
                        phase_eff = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        for (int i = 0; i < NSEP; i++)
                        begin
                            row_eff[i] = el_cnt[i];
                        end
                        phase_eff = PH_CHECK;
                    end
                    PH_CHECK:
                    begin
                        if (rows_reg < check_rows_reg)
                        begin
                            for (int i = 0; i < NSEP; i++)
                            begin
                                if (el_cnt[i] != row_reg[i])
                                begin
                                    incon_eff[i] = 1'b1;
                                end
                            end
                            rows_eff = rows_reg + 4'd1;
                        end
                    end
                    default:
                    begin
                        phase_eff = phase_reg;
                    end
                endcase
            end
        end
    end

    // Decision over the state as it stands after the final line.
    always_comb
    begin
        logic [1:0] hs_idx;
        logic [1:0] ds_idx;
        logic [1:0] hits;
        logic       hit;
        logic       any;

        hs_idx = 2'd0;
        ds_idx = 2'd0;
        hits   = 2'd0;
        any    = 1'b0;
        for (int i = 0; i < NSEP; i++)
        begin
            for (int j = 0; j < NSEP; j++)
            begin
                if (phase_eff == PH_CHECK)
                begin
                    hit = hdr_eff[i] != CNT_ZERO && !incon_eff[j] && hdr_eff[i] == row_eff[j];
                end
                else
                begin
                    hit = (i == j) && hdr_eff[i] != CNT_ZERO;
                end
                if (hit)
                begin
                    hs_idx = 2'(i);
                    ds_idx = 2'(j);
                    hits   = (hits == 2'd2) ? 2'd2 : hits + 2'd1;
                end
            end
            if (hdr_eff[i] != CNT_ZERO || row_eff[i] != CNT_ZERO || incon_eff[i])
            begin
                any = 1'b1;
            end
        end

        if (phase_eff == PH_HEADER)
        begin
            dec_status = ST_NO_LINE;
        end
        else if (hits == 2'd1)
        begin
            dec_status = ST_FOUND;
        end
        else if (hits == 2'd2 || any)
        begin
            dec_status = ST_AMBIG;
        end
        else
        begin
            dec_status = ST_NO_SEP;
        end

        dec_hs = (dec_status == ST_FOUND) ? SEP_BYTES[hs_idx] : 8'h00;
        dec_ds = (dec_status == ST_FOUND) ? SEP_BYTES[ds_idx] : 8'h00;
    end

    // End of data returns the block to its reset state; otherwise carry the update.
    always_comb
    begin
        if (in_last_reg)
        begin
            phase_next = PH_HEADER;
            rows_next  = 4'd0;
            incon_next = '0;
            for (int i = 0; i < NSEP; i++)
            begin
                hdr_next[i] = CNT_ZERO;
                row_next[i] = CNT_ZERO;
            end
        end
        else
        begin
            phase_next = phase_eff;
            rows_next  = rows_eff;
            incon_next = incon_eff;
            for (int i = 0; i < NSEP; i++)
            begin
                hdr_next[i] = hdr_eff[i];
                row_next[i] = row_eff[i];
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= MAX_LINE_RESET;
            check_rows_reg <= CHECK_ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_LINE_LENGTH: max_len_reg    <= cfg_data;
                REG_CHECK_ROWS:      check_rows_reg <= cfg_data[3:0];
                default:             max_len_reg    <= max_len_reg;
            endcase
        end
    end

    // Input register: hold the beat until the stage takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Line and file state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            acr_reg   <= 1'b0;
            chunk_reg <= 16'd0;
            rows_reg  <= 4'd0;
            incon_reg <= '0;
            for (int i = 0; i < NSEP; i++)
            begin
                lc_reg[i]  <= CNT_ZERO;
                hdr_reg[i] <= CNT_ZERO;
                row_reg[i] <= CNT_ZERO;
            end
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            acr_reg   <= acr_next;
            chunk_reg <= chunk_next;
            rows_reg  <= rows_next;
            incon_reg <= incon_next;
            for (int i = 0; i < NSEP; i++)
            begin
                lc_reg[i]  <= lc_next[i];
                hdr_reg[i] <= hdr_next[i];
                row_reg[i] <= row_next[i];
            end
        end
    end

    // Result register: load on end of data, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (proc && in_last_reg)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            m_data_reg   <= {dec_ds, dec_hs};
            m_status_reg <= dec_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // Separators are reported only with a found status.
    a_sep_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg != ST_FOUND) |-> m_data_reg == 16'd0)
        else $error("separator bytes set with a non-found status");

    // End of data leaves the block in its reset state.
    a_eod_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=> (phase_reg == PH_HEADER && chunk_reg == 16'd0
                                   && !acr_reg && rows_reg == 4'd0))
        else $error("state not cleared after end of data");

    // Row checking only happens after the first data row.
    a_check_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_CHECK) |-> (rows_reg == 4'd0 && incon_reg == '0))
        else $error("row check state outside the check phase");

    // A new result appears only after an end-of-data beat went through.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(proc && in_last_reg))
        else $error("result without end of data");

endmodule

### tb/sv/tb_field_separator_detector_top.sv
// Testbench: field_separator_detector_top driven as a byte stream and checked against a predictor.
`timescale 1ns / 100ps

module tb_field_separator_detector_top;
    import fsd_pkg::*;

    // Counter width of the block as built (default parameter)
    localparam int CNT_W = 16;
    // Result reaches the master side through the result register once the end-of-data beat is taken
    localparam int RESULT_LATENCY = 1;
    // Long receiver hold-off used to back the block up
    localparam int HOLD_OFF_CYCLES = 300;
    // Anything past this limit is a hang
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BEATS = 950;
    localparam int RANDOM_FILES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        status_t    status;
        logic [7:0] hsep;
        logic [7:0] dsep;
    } decision_t;

    typedef logic [CNT_W-1:0] sep_counts_t [NSEP];

    // Predictor of the separator decision plus the queue of decisions still owed
    class separator_scoreboard;
        logic [15:0]  max_line;
        logic [3:0]   check_limit;
        phase_t       ph;
        bit           after_cr;
        logic [15:0]  chunk_len;
        sep_counts_t  line_cnt;
        sep_counts_t  head_cnt;
        sep_counts_t  row_cnt;
        bit           row_bad [NSEP];
        logic [3:0]   rows_done;
        decision_t    expected_decisions [$];
        int           mismatches;

        function new();
            max_line    = MAX_LINE_RESET;
            check_limit = CHECK_ROWS_RESET;
            mismatches  = 0;
            clear_state();
        endfunction

        function void clear_state();
            ph        = PH_HEADER;
            after_cr  = 1'b0;
            chunk_len = '0;
            rows_done = '0;
            for (int i = 0; i < NSEP; i++)
            begin
                line_cnt[i] = '0;
                head_cnt[i] = '0;
                row_cnt[i]  = '0;
                row_bad[i]  = 1'b0;
            end
        endfunction

        function void write_reg(reg_index_t idx, logic [15:0] value);
            case (idx)
                REG_MAX_LINE_LENGTH: max_line = value;
                REG_CHECK_ROWS:      check_limit = value[3:0];
                default: ;
            endcase
        endfunction

        // Close the current line or chunk; only non-empty ones move the phase on
        function void close_line(bit nonempty);
            if (nonempty)
            begin
                case (ph)
                    PH_HEADER:
                    begin
                        head_cnt = line_cnt;
                        ph = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        row_cnt = line_cnt;
                        ph = PH_CHECK;
                    end
                    default:
                    begin
                        // rows past the limit (even one lowered mid-file) are dropped
                        if (rows_done < check_limit)
                        begin
                            for (int i = 0; i < NSEP; i++)
                                if (line_cnt[i] != row_cnt[i])
                                    row_bad[i] = 1'b1;
                            rows_done++;
                        end
                    end
                endcase
            end
            chunk_len = '0;
            for (int i = 0; i < NSEP; i++)
                line_cnt[i] = '0;
        endfunction

        function decision_t predict_decision();
            decision_t d;
            int        hits;
            bit        any;
            d.status = ST_FOUND;
            d.hsep   = '0;
            d.dsep   = '0;
            hits     = 0;
            any      = 1'b0;
            if (ph == PH_HEADER)
                d.status = ST_NO_LINE;
            else
            begin
                for (int i = 0; i < NSEP; i++)
                begin
                    if (ph == PH_CHECK)
                    begin
                        for (int j = 0; j < NSEP; j++)
                            if (head_cnt[i] != 0 && !row_bad[j] && head_cnt[i] == row_cnt[j])
                            begin
                                d.hsep = SEP_BYTES[i];
                                d.dsep = SEP_BYTES[j];
                                hits++;
                            end
                    end
                    else if (head_cnt[i] != 0)
                    begin
                        // header only: the header separator stands for both
                        d.hsep = SEP_BYTES[i];
                        d.dsep = SEP_BYTES[i];
                        hits++;
                    end
                end
                if (hits == 1)
                    d.status = ST_FOUND;
                else if (hits > 1)
                    d.status = ST_AMBIG;
                else
                begin
                    for (int i = 0; i < NSEP; i++)
                        if (head_cnt[i] != 0 || row_cnt[i] != 0 || row_bad[i])
                            any = 1'b1;
                    d.status = any ? ST_AMBIG : ST_NO_SEP;
                end
            end
            if (d.status != ST_FOUND)
            begin
                d.hsep = '0;
                d.dsep = '0;
            end
            return d;
        endfunction

        // Advance the predictor by one accepted input beat
        function void note_beat(logic [7:0] b, logic last);
            if (last)
            begin
                after_cr = 1'b0;
                if (chunk_len != 0)
                    close_line(1'b1);
                expected_decisions.insert(expected_decisions.size(), predict_decision());
                clear_state();
                return;
            end
            if (after_cr)
            begin
                // LF straight after CR belongs to the same line break
                after_cr = 1'b0;
                if (b == CHAR_LF)
                    return;
            end
            if (b == CHAR_LF)
                close_line(chunk_len != 0);
            else if (b == CHAR_CR)
            begin
                close_line(chunk_len != 0);
                after_cr = 1'b1;
            end
            else
            begin
                for (int i = 0; i < NSEP; i++)
                    if (b == SEP_BYTES[i] && line_cnt[i] != {CNT_W{1'b1}})
                        line_cnt[i]++;
                chunk_len++;
                // 16-bit wrap makes a zero limit act as 65536
                if (chunk_len == max_line)
                    close_line(1'b1);
            end
        endfunction

        function void check_result(logic [1:0] status, logic [7:0] hsep, logic [7:0] dsep);
            decision_t want;
            if (expected_decisions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: status %0d hsep %02h dsep %02h",
                             $time, status, hsep, dsep);
                return;
            end
            want = expected_decisions.pop_front();
            if (want.status != status || want.hsep != hsep || want.dsep != dsep)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch exp/got: status %0d/%0d hsep %02h/%02h dsep %02h/%02h",
                             $time, want.status, status, want.hsep, hsep, want.dsep, dsep);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic        s_tlast;     // end_of_data
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // [7:0] header separator byte, [15:8] row separator byte
    logic [1:0]  m_tuser;     // [1:0] status

    separator_scoreboard sb = new();

    int  beats_sent   = 0;    // input beats taken by the block
    int  files_sent   = 0;    // end-of-data beats taken by the block
    int  results_seen = 0;    // decisions taken from the block
    int  cycle_count  = 0;
    bit  idle_on      = 1'b0; // random gaps on both sides
    bit  hold_off_req = 1'b0; // ask the receiver for one long hold-off

    field_separator_detector_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitors: sample handshakes at the edge, before anything driven there settles
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_beat(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tuser, m_tdata[7:0], m_tdata[15:8]);
            results_seen++;
        end
    end

    // Watchdog: end the run if the stream hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_field_separator_detector_top: errors");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one beat, hold it until taken, then maybe drop valid for a while
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
        if (last)
            files_sent++;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = idle_len();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string txt);
        for (int k = 0; k < txt.len(); k++)
            send_beat(txt[k], 1'b0);
    endtask

    task automatic send_eod();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Drain: every decision in, then let the result register go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_seen < files_sent)
            @(posedge clk);
        repeat (RESULT_LATENCY + 3) @(posedge clk);
    endtask

    // Write one register; the block must be idle
    task automatic program_reg(input reg_index_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.write_reg(idx, value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Field content: letters, digits, stray separators, high bytes
    function automatic logic [7:0] field_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 16)
            return 8'h30 + 8'($urandom_range(0, 9));
        else if (r < 18)
            return SEP_BYTES[2'($urandom_range(0, NSEP - 1))];
        else
            return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    // Raw noise, weighted towards line breaks and separators
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return CHAR_LF;
            1:       return CHAR_CR;
            2, 3:    return SEP_BYTES[2'($urandom_range(0, NSEP - 1))];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_line(input logic [7:0] sep, input int fields, input bit terminate);
        int n;
        for (int f = 0; f < fields; f++)
        begin
            if (f != 0)
                send_beat(sep, 1'b0);
            n = $urandom_range(0, 3);
            repeat (n) send_beat(field_char(), 1'b0);
        end
        if (terminate)
        begin
            case ($urandom_range(0, 2))
                0: send_beat(CHAR_LF, 1'b0);
                1: send_beat(CHAR_CR, 1'b0);
                default:
                begin
                    send_beat(CHAR_CR, 1'b0);
                    send_beat(CHAR_LF, 1'b0);
                end
            endcase
        end
    endtask

    // One file: mostly a delimited table with random content, sometimes pure noise
    task automatic send_random_file();
        logic [7:0] head_sep;
        logic [7:0] row_sep;
        int         fields;
        int         rows;
        int         width;
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(0, 24)) send_beat(noise_byte(), 1'b0);
        end
        else
        begin
            head_sep = SEP_BYTES[2'($urandom_range(0, NSEP - 1))];
            row_sep  = ($urandom_range(0, 2) == 0) ? SEP_BYTES[2'($urandom_range(0, NSEP - 1))]
                                                   : head_sep;
            fields = $urandom_range(1, 4);
            rows   = $urandom_range(0, 4);
            for (int r = 0; r <= rows; r++)
            begin
                // blank line, skipped by the block
                if ($urandom_range(0, 7) == 0)
                    send_beat($urandom_range(0, 1) ? CHAR_LF : CHAR_CR, 1'b0);
                // ragged row now and then breaks consistency
                width = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : fields;
                send_line((r == 0) ? head_sep : row_sep, width,
                          (r != rows) || $urandom_range(0, 1));
            end
        end
        send_eod();
    endtask

    initial
    begin
        // Register settings cycled by the random phases; extremes included
        logic [15:0] len_set [8];
        logic [3:0]  rows_set [8];
        int          base_beats;
        int          base_files;
        int          ph_idx;
        logic [15:0] len_val;

        len_set  = '{16'd1, 16'd3, 16'd65535, 16'd7, 16'd16, 16'd2, 16'd65535, 16'd24};
        rows_set = '{4'd0, 4'd15, 4'd10, 4'd1, 4'd4, 4'd7, 4'd15, 4'd2};

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_MAX_LINE_LENGTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values
        idle_on = 1'b0;
        send_eod();                       // no non-empty line at all
        send_beat(CHAR_CR, 1'b0);         // blank lines in CR LF, then LF
        send_beat(CHAR_LF, 1'b0);
        send_beat(CHAR_LF, 1'b0);
        send_text("x");                   // header without any separator
        send_eod();
        send_text("a;b");                 // header and data row disagree on separator
        send_beat(CHAR_CR, 1'b0);
        send_text("1,2");
        send_eod();
        send_beat(SEP_BYTES[1], 1'b0);    // tab and space both in header: ambiguous
        send_beat(SEP_BYTES[2], 1'b0);
        send_beat(CHAR_LF, 1'b0);
        send_eod();
        send_beat(8'hFF, 1'b0);           // byte extremes
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        settle();

        // Zero line limit acts as 65536: a run of commas stays one uncut line
        program_reg(REG_MAX_LINE_LENGTH, 16'd0);
        repeat (40) send_beat(SEP_BYTES[0], 1'b0);
        send_eod();
        settle();

        // Lower check_rows part way into a file: later rows drop out of the check
        program_reg(REG_MAX_LINE_LENGTH, 16'd65535);
        program_reg(REG_CHECK_ROWS, {12'hABC, 4'd15});
        idle_on = 1'b1;
        send_text("a,b");
        send_beat(CHAR_LF, 1'b0);
        send_text("1,2");
        send_beat(CHAR_LF, 1'b0);
        repeat (5)
        begin
            send_text("3,4");
            send_beat(CHAR_CR, 1'b0);
        end
        settle();
        program_reg(REG_CHECK_ROWS, {12'h000, 4'd2});
        send_text("5;6,,7");
        send_beat(CHAR_LF, 1'b0);
        send_eod();
        settle();

        // Random phases, each under its own register setting
        base_beats = beats_sent;
        base_files = files_sent;
        ph_idx = 0;
        while (beats_sent - base_beats < RANDOM_BEATS || files_sent - base_files < RANDOM_FILES)
        begin
            len_val = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 30))
                                                  : len_set[3'(ph_idx % 8)];
            program_reg(REG_MAX_LINE_LENGTH, len_val);
            program_reg(REG_CHECK_ROWS, {12'($urandom_range(0, 4095)), rows_set[3'(ph_idx % 8)]});
            // every third phase runs flat out on both sides
            idle_on = (ph_idx % 3) != 2;
            if (ph_idx == 1)
            begin
                // hold the receiver off and offer twelve short files so that the block backs up
                hold_off_req = 1'b1;
                repeat (12)
                begin
                    if ($urandom_range(0, 2) != 0)
                        send_eod();
                    else
                        send_random_file();
                end
            end
            repeat (6) send_random_file();
            settle();
            ph_idx++;
        end

        if (sb.mismatches == 0 && sb.expected_decisions.size() == 0)
            $display("tb_field_separator_detector_top: clean");
        else
            $display("tb_field_separator_detector_top: errors");
        $finish;
    end

endmodule
